/* sv/cfd_pkg.sv */
// Shared types, constants and CRC functions for the framed-byte deframer.
// No dependencies; imported by every module of the deframer.
package cfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CMD_W  = 16;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_W  = 11;

  // Hard ceiling on the payload length, and the payload counter width it needs
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(1024);
  localparam logic [BYTE_W-1:0] SOF_BYTE  = 8'hA5;
  localparam logic [7:0]        HCRC_SEED  = 8'hFF;
  localparam logic [15:0]       CRC16_INIT = 16'hFFFF;
  localparam logic [7:0]        CRC8_POLY  = 8'h8C;
  localparam logic [15:0]       CRC16_POLY = 16'h8408;

  // Command ids handled downstream
  localparam logic [CMD_W-1:0] CMD_ID_0 = 16'h0201;
  localparam logic [CMD_W-1:0] CMD_ID_1 = 16'h0202;
  localparam logic [CMD_W-1:0] CMD_ID_2 = 16'h0206;
  localparam logic [CMD_W-1:0] CMD_ID_3 = 16'h0207;
  localparam logic [CMD_W-1:0] CMD_ID_4 = 16'h0001;
  localparam logic [CMD_W-1:0] CMD_ID_5 = 16'h0003;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_LEN_LO  = 4'd1,
    PH_LEN_HI  = 4'd2,
    PH_SEQ     = 4'd3,
    PH_HCRC    = 4'd4,
    PH_CMD_LO  = 4'd5,
    PH_CMD_HI  = 4'd6,
    PH_DATA    = 4'd7,
    PH_FCRC_LO = 4'd8,
    PH_FCRC_HI = 4'd9
  } cfd_phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC16_BAD = 3'd2,
    KIND_CRC8_BAD  = 3'd3,
    KIND_TOO_LONG  = 3'd4
  } cfd_kind_e;

  // One result record, with its valid flag
  typedef struct packed {
    logic                 valid;
    cfd_kind_e            kind;
    logic [CMD_W-1:0]     command_id;
    logic [BYTE_W-1:0]    payload_byte;
    logic [OFF_W-1:0]     byte_offset;
    logic [LEN_W-1:0]     payload_length;
    logic [BYTE_W-1:0]    sequence_res;
    logic                 known_id;
    logic                 last;
  } cfd_result_t;

  // Reflected CRC8 update, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC8_POLY : 8'h00);
    end
    return c;
  endfunction

  // Reflected CRC16 update, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic is_known(input logic [CMD_W-1:0] id);
    return (id == CMD_ID_0) || (id == CMD_ID_1) || (id == CMD_ID_2) ||
           (id == CMD_ID_3) || (id == CMD_ID_4) || (id == CMD_ID_5);
  endfunction

endpackage

/* sv/crc_checked_frame_deframer_core.sv */
// Byte-serial frame deframer with header CRC8 and frame CRC16 checks.
// Input channel: one received byte per request on rx_byte_i (in_valid_i /
// in_ready_o). The parser hunts for 0xA5, reads length, sequence, header
// CRC8, command id, payload and the trailing CRC16.
// Output channel (out_valid_o / out_ready_i): one record per payload byte
// and one closing record per frame or dropped header; header bytes give none.
// cfg_we_i / cfg_wdata_i write the payload length limit.
// The byte sits in the input register first; its outcome is loaded into the
// result register when the parser advances. Throughput: one byte per cycle
// while the result register is free, set by the combinational CRC step and
// phase update between the two registers.
// A stalled receiver holds the result register; one more byte waits in the
// input register and in_ready_o falls only when both are full.
// Reset (rst_ni low, asynchronous) empties both registers, returns the
// parser to hunting and sets the limit to 1024.
// Depends on cfd_pkg, cfd_in_stage, cfd_parser and cfd_out_stage.
module crc_checked_frame_deframer_core import cfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [CMD_W-1:0]  command_id_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [OFF_W-1:0]  byte_offset_o,
  output logic [LEN_W-1:0]  payload_length_o,
  output logic [BYTE_W-1:0] sequence_res_o,
  output logic              known_id_o,
  output logic              last_o
);

  logic [CFG_W-1:0]  max_len_q;
  logic              out_free;
  logic              advance;
  logic [BYTE_W-1:0] held_byte;
  cfd_result_t       step_res;
  cfd_result_t       out_res;

  // Hold the length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  cfd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_free_i (out_free),
    .advance_o  (advance),
    .byte_o     (held_byte)
  );

  cfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (held_byte),
    .max_len_i (max_len_q),
    .result_o  (step_res)
  );

  cfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_free_o  (out_free),
    .result_o    (out_res)
  );

  assign kind_o           = out_res.kind;
  assign command_id_o     = out_res.command_id;
  assign payload_byte_o   = out_res.payload_byte;
  assign byte_offset_o    = out_res.byte_offset;
  assign payload_length_o = out_res.payload_length;
  assign sequence_res_o   = out_res.sequence_res;
  assign known_id_o       = out_res.known_id;
  assign last_o           = out_res.last;

`ifndef SYNTHESIS
  // Backpressure reaches the input only through a full, stalled result slot
  a_ready_low_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // Payload records never close a frame and sit inside the payload
  a_payload_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_PAYLOAD)) |->
      (!last_o && ({6'b0, byte_offset_o} < payload_length_o)))
    else $error("payload record out of shape");

  // Dropped headers carry no command information
  a_drop_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((kind_o == KIND_CRC8_BAD) || (kind_o == KIND_TOO_LONG))) |->
      (last_o && (command_id_o == '0) && !known_id_o))
    else $error("dropped header carries a command id");

  // A length-limit drop only reports lengths above the limit
  a_too_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_TOO_LONG)) |->
      (payload_length_o > LEN_W'(max_len_q)) ||
      (payload_length_o > LEN_W'(MAX_PAYLOAD)))
    else $error("length drop for an allowed length");
`endif

endmodule

/* sv/cfd_in_stage.sv */
// Input register of the deframer: holds one received byte until the
// parser takes it. Depends on cfd_pkg.
module cfd_in_stage import cfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              out_free_i,
  output logic              advance_o,
  output logic [BYTE_W-1:0] byte_o
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  // Advance when a byte is held and the result slot can take its outcome
  assign advance_o  = valid_q && out_free_i;
  assign in_ready_o = !valid_q || advance_o;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new request whenever the slot opens
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

/* sv/cfd_parser.sv */
// Frame parser: phase state machine, header fields, running CRCs and the
// payload counter; forms the result of each byte. Depends on cfd_pkg.
module cfd_parser import cfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [CFG_W-1:0]  max_len_i,
  output cfd_result_t       result_o
);

  localparam logic [7:0]  CRC8_SOF  = crc8_step(HCRC_SEED, SOF_BYTE);
  localparam logic [15:0] CRC16_SOF = crc16_step(CRC16_INIT, SOF_BYTE);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  cfd_phase_e        phase_q, phase_d;
  logic [LEN_W-1:0]  length_q, length_d;
  logic [BYTE_W-1:0] seq_q, seq_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [7:0]        crc8_q, crc8_d;
  logic [15:0]       crc16_q, crc16_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] crc_lo_q, crc_lo_d;

  logic [15:0]       crc16_upd;
  logic [7:0]        crc8_upd;
  logic [CNT_W-1:0]  count_inc;
  logic [LEN_W-1:0]  limit;

  assign crc8_upd  = crc8_step(crc8_q, byte_i);
  assign crc16_upd = crc16_step(crc16_q, byte_i);
  assign count_inc = count_q + CNT_W'(1);
  assign limit     = (LEN_W'(max_len_i) > MAX_LEN) ? MAX_LEN : LEN_W'(max_len_i);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    seq_d    = seq_q;
    cmd_d    = cmd_q;
    crc8_d   = crc8_q;
    crc16_d  = crc16_q;
    count_d  = count_q;
    crc_lo_d = crc_lo_q;

    result_o                = '0;
    result_o.kind           = KIND_PAYLOAD;
    result_o.payload_length = length_q;
    result_o.sequence_res   = seq_q;

    unique case (phase_q)
      PH_LEN_LO: begin
        length_d = {8'h00, byte_i};
        crc8_d   = crc8_upd;
        crc16_d  = crc16_upd;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = {byte_i, length_q[7:0]};
        crc8_d   = crc8_upd;
        crc16_d  = crc16_upd;
        phase_d  = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d   = byte_i;
        crc8_d  = crc8_upd;
        crc16_d = crc16_upd;
        phase_d = PH_HCRC;
      end
      PH_HCRC: begin
        // Drop the header on a CRC8 mismatch, then on an oversized length
        if (byte_i != crc8_q) begin
          phase_d         = PH_HUNT;
          result_o.valid  = 1'b1;
          result_o.kind   = KIND_CRC8_BAD;
          result_o.last   = 1'b1;
        end else if (length_q > limit) begin
          phase_d         = PH_HUNT;
          result_o.valid  = 1'b1;
          result_o.kind   = KIND_TOO_LONG;
          result_o.last   = 1'b1;
        end else begin
          crc16_d = crc16_upd;
          phase_d = PH_CMD_LO;
        end
      end
      PH_CMD_LO: begin
        cmd_d   = {8'h00, byte_i};
        crc16_d = crc16_upd;
        phase_d = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        cmd_d   = {byte_i, cmd_q[7:0]};
        crc16_d = crc16_upd;
        count_d = '0;
        phase_d = (length_q == '0) ? PH_FCRC_LO : PH_DATA;
      end
      PH_DATA: begin
        crc16_d                = crc16_upd;
        result_o.valid         = 1'b1;
        result_o.kind          = KIND_PAYLOAD;
        result_o.command_id    = cmd_q;
        result_o.known_id      = is_known(cmd_q);
        result_o.payload_byte  = byte_i;
        result_o.byte_offset   = OFF_W'(count_q);
        count_d                = count_inc;
        if (LEN_W'(count_inc) >= length_q) begin
          phase_d = PH_FCRC_LO;
        end
      end
      PH_FCRC_LO: begin
        crc_lo_d = byte_i;
        phase_d  = PH_FCRC_HI;
      end
      PH_FCRC_HI: begin
        phase_d             = PH_HUNT;
        result_o.valid      = 1'b1;
        result_o.command_id = cmd_q;
        result_o.known_id   = is_known(cmd_q);
        result_o.last       = 1'b1;
        result_o.kind       = ((crc_lo_q == crc16_q[7:0]) && (byte_i == crc16_q[15:8])) ?
                              KIND_GOOD : KIND_CRC16_BAD;
      end
      default: begin
        // Hunt for the start byte; unused codes land here as well
        phase_d = PH_HUNT;
        if (byte_i == SOF_BYTE) begin
          crc8_d  = CRC8_SOF;
          crc16_d = CRC16_SOF;
          phase_d = PH_LEN_LO;
        end
      end
    endcase
  end

  // Advance the parse state once per byte taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      length_q <= '0;
      seq_q    <= '0;
      cmd_q    <= '0;
      crc8_q   <= HCRC_SEED;
      crc16_q  <= CRC16_INIT;
      count_q  <= '0;
      crc_lo_q <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      seq_q    <= seq_d;
      cmd_q    <= cmd_d;
      crc8_q   <= crc8_d;
      crc16_q  <= crc16_d;
      count_q  <= count_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

/* sv/cfd_out_stage.sv */
// Result register of the deframer: holds one result until the receiver
// takes it. Depends on cfd_pkg.
module cfd_out_stage import cfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  cfd_result_t result_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        out_free_o,
  output cfd_result_t result_o
);

  logic        valid_q, valid_d;
  cfd_result_t data_q;

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  // Fill on a load, drain when the receiver takes the request
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = result_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      data_q <= result_i;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for crc_checked_frame_deframer_core: frames built with their own
// CRCs, a byte-level parser predictor and a scoreboard of expected records.
// Depends on cfd_pkg and the deframer RTL only.
module testbench;
  import cfd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;

  typedef logic [BYTE_W-1:0] octet_t;

  typedef struct packed {
    cfd_kind_e         kind;
    logic [CMD_W-1:0]  command_id;
    octet_t            payload_byte;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  payload_length;
    octet_t            sequence_res;
    logic              known_id;
    logic              last;
  } deframe_rec_t;

  // One directed frame: filler before it, header fields, payload fill, faults, closing kind
  typedef struct packed {
    logic [3:0]        noise;
    logic [LEN_W-1:0]  len;
    octet_t            seq;
    logic [CMD_W-1:0]  cmd;
    logic              fill_on;
    octet_t            fill;
    logic              hdr_bad;
    logic              crc_bad;
    logic              typed;
    cfd_kind_e         want;
  } frame_row_t;

  typedef struct {
    bit        typed;
    cfd_kind_e kind;
  } end_note_t;

  typedef struct packed {
    logic [6:0]        send_pct;
    logic [6:0]        recv_pct;
    logic [CFG_W-1:0]  limit;
    logic              limit_rand;
    logic [9:0]        n_bytes;
  } traffic_phase_t;

  localparam frame_row_t DIRECTED_ROWS [9] = '{
    '{4'd3, 16'd0,     8'h00, 16'h0000, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, KIND_GOOD},
    '{4'd0, 16'd1,     8'hFF, 16'hFFFF, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b1, KIND_GOOD},
    '{4'd0, 16'd3,     8'h5A, CMD_ID_0, 1'b1, 8'hA5, 1'b0, 1'b0, 1'b1, KIND_GOOD},
    '{4'd0, 16'd2,     8'h01, CMD_ID_4, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, KIND_CRC16_BAD},
    '{4'd1, 16'd4,     8'h80, CMD_ID_1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, KIND_CRC8_BAD},
    '{4'd0, 16'd1025,  8'h7F, CMD_ID_2, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, KIND_TOO_LONG},
    '{4'd0, 16'hFFFF,  8'h00, CMD_ID_3, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, KIND_TOO_LONG},
    '{4'd0, 16'd5,     8'h33, CMD_ID_5, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, KIND_GOOD},
    '{4'd2, 16'd2,     8'hC3, 16'h1234, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, KIND_GOOD}
  };

  localparam traffic_phase_t TRAFFIC_PHASES [5] = '{
    '{7'd15, 7'd80, 11'd0,    1'b0, 10'd40},
    '{7'd15, 7'd80, 11'd2047, 1'b0, 10'd60},
    '{7'd80, 7'd15, 11'd0,    1'b1, 10'd70},
    '{7'd80, 7'd15, 11'd13,   1'b0, 10'd40},
    '{7'd0,  7'd0,  11'd1024, 1'b0, 10'd60}
  };

  localparam logic [CMD_W-1:0] KNOWN_IDS [6] = '{
    CMD_ID_0, CMD_ID_1, CMD_ID_2, CMD_ID_3, CMD_ID_4, CMD_ID_5
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  octet_t            rx_byte_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [CMD_W-1:0]  command_id_o;
  octet_t            payload_byte_o;
  logic [OFF_W-1:0]  byte_offset_o;
  logic [LEN_W-1:0]  payload_length_o;
  octet_t            sequence_res_o;
  logic              known_id_o;
  logic              last_o;

  // Predictor copy of the parser state and the length limit
  cfd_phase_e        parse_ph = PH_HUNT;
  logic [LEN_W-1:0]  len_q = '0;
  octet_t            seq_q = '0;
  logic [CMD_W-1:0]  cmd_q = '0;
  logic [7:0]        hdr_crc_q = HCRC_SEED;
  logic [15:0]       frame_crc_q = CRC16_INIT;
  logic [15:0]       data_cnt_q = '0;
  octet_t            crc_lo_q = '0;
  logic [CFG_W-1:0]  limit_reg_q = CFG_RESET;

  deframe_rec_t      pending_recs [$];
  end_note_t         end_notes [$];
  octet_t            tx_bytes [$];
  octet_t            frame_buf [$];
  logic              byte_taken = 1'b0;
  int unsigned       send_idle_pct = 15;
  int unsigned       recv_idle_pct = 80;
  int unsigned       mismatches = 0;

  crc_checked_frame_deframer_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .command_id_o     (command_id_o),
    .payload_byte_o   (payload_byte_o),
    .byte_offset_o    (byte_offset_o),
    .payload_length_o (payload_length_o),
    .sequence_res_o   (sequence_res_o),
    .known_id_o       (known_id_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Bit-serial reflected CRC updates, LSB of the byte first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input octet_t b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CRC8_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input octet_t b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CRC16_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic known_cmd(input logic [CMD_W-1:0] id);
    logic hit;
    hit = 1'b0;
    foreach (KNOWN_IDS[i]) if (KNOWN_IDS[i] == id) hit = 1'b1;
    return hit;
  endfunction

  function automatic int unsigned limit_now();
    return (limit_reg_q > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(limit_reg_q);
  endfunction

  // Advance the parser predictor by one accepted byte; queue the record it causes
  task automatic deframe_byte(input octet_t b);
    deframe_rec_t rec;
    end_note_t    note;
    bit           emit;
    bit           closing;
    rec = '0;
    emit = 1'b0;
    closing = 1'b0;
    rec.payload_length = len_q;
    rec.sequence_res   = seq_q;
    case (parse_ph)
      PH_LEN_LO: begin
        len_q = {8'h00, b};
        hdr_crc_q = crc8_next(hdr_crc_q, b);
        frame_crc_q = crc16_next(frame_crc_q, b);
        parse_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_q[15:8] = b;
        hdr_crc_q = crc8_next(hdr_crc_q, b);
        frame_crc_q = crc16_next(frame_crc_q, b);
        parse_ph = PH_SEQ;
      end
      PH_SEQ: begin
        seq_q = b;
        hdr_crc_q = crc8_next(hdr_crc_q, b);
        frame_crc_q = crc16_next(frame_crc_q, b);
        parse_ph = PH_HCRC;
      end
      PH_HCRC: begin
        rec.payload_length = len_q;
        rec.sequence_res   = seq_q;
        if (b != hdr_crc_q) begin
          rec.kind = KIND_CRC8_BAD;
          emit = 1'b1;
          parse_ph = PH_HUNT;
        end else if (len_q > limit_now()) begin
          rec.kind = KIND_TOO_LONG;
          emit = 1'b1;
          parse_ph = PH_HUNT;
        end else begin
          frame_crc_q = crc16_next(frame_crc_q, b);
          parse_ph = PH_CMD_LO;
        end
        closing = emit;
      end
      PH_CMD_LO: begin
        cmd_q = {8'h00, b};
        frame_crc_q = crc16_next(frame_crc_q, b);
        parse_ph = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        cmd_q[15:8] = b;
        frame_crc_q = crc16_next(frame_crc_q, b);
        data_cnt_q = '0;
        parse_ph = (len_q == 0) ? PH_FCRC_LO : PH_DATA;
      end
      PH_DATA: begin
        frame_crc_q = crc16_next(frame_crc_q, b);
        rec.kind = KIND_PAYLOAD;
        rec.command_id = cmd_q;
        rec.known_id = known_cmd(cmd_q);
        rec.payload_byte = b;
        rec.byte_offset = data_cnt_q[OFF_W-1:0];
        emit = 1'b1;
        data_cnt_q = data_cnt_q + 16'd1;
        if (data_cnt_q >= len_q) parse_ph = PH_FCRC_LO;
      end
      PH_FCRC_LO: begin
        crc_lo_q = b;
        parse_ph = PH_FCRC_HI;
      end
      PH_FCRC_HI: begin
        rec.kind = (crc_lo_q == frame_crc_q[7:0] && b == frame_crc_q[15:8]) ?
                   KIND_GOOD : KIND_CRC16_BAD;
        rec.command_id = cmd_q;
        rec.known_id = known_cmd(cmd_q);
        emit = 1'b1;
        closing = 1'b1;
        parse_ph = PH_HUNT;
      end
      default: begin
        parse_ph = PH_HUNT;
        if (b == SOF_BYTE) begin
          hdr_crc_q = crc8_next(HCRC_SEED, b);
          frame_crc_q = crc16_next(CRC16_INIT, b);
          parse_ph = PH_LEN_LO;
        end
      end
    endcase
    if (emit) begin
      rec.last = closing;
      // Directed frames carry the closing kind read off the table
      if (closing && end_notes.size() != 0) begin
        note = end_notes.pop_front();
        if (note.typed) rec.kind = note.kind;
      end
      pending_recs.push_back(rec);
    end
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Fill frame_buf with one frame; head_only stops after the header CRC8
  task automatic build_frame(input logic [LEN_W-1:0] len, input octet_t seq,
                             input logic [CMD_W-1:0] cmd, input bit fill_on,
                             input octet_t fill, input bit hdr_bad, input bit crc_bad,
                             input bit head_only);
    logic [7:0]  h;
    logic [15:0] f;
    int unsigned i;
    frame_buf.delete();
    frame_buf.push_back(SOF_BYTE);
    frame_buf.push_back(len[7:0]);
    frame_buf.push_back(len[15:8]);
    frame_buf.push_back(seq);
    h = HCRC_SEED;
    foreach (frame_buf[k]) h = crc8_next(h, frame_buf[k]);
    if (hdr_bad) h ^= 8'($urandom_range(255, 1));
    frame_buf.push_back(h);
    if (!head_only) begin
      frame_buf.push_back(cmd[7:0]);
      frame_buf.push_back(cmd[15:8]);
      for (i = 0; i < len; i++) frame_buf.push_back(fill_on ? fill : 8'($urandom_range(255)));
      f = CRC16_INIT;
      foreach (frame_buf[k]) f = crc16_next(f, frame_buf[k]);
      if (crc_bad) begin
        if ($urandom_range(1)) f[7:0] ^= 8'($urandom_range(255, 1));
        else f[15:8] ^= 8'($urandom_range(255, 1));
      end
      frame_buf.push_back(f[7:0]);
      frame_buf.push_back(f[15:8]);
    end
  endtask

  // Random frames, mostly well formed, with dropped headers, bad CRCs, cuts and noise
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned      queued;
    int unsigned      pick;
    int unsigned      lim;
    int unsigned      len;
    logic [CMD_W-1:0] cmd;
    queued = 0;
    lim = limit_now();
    while (queued < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(4, 1)) begin
          tx_bytes.push_back(8'($urandom_range(255)));
          queued++;
        end
      end else begin
        len = $urandom_range(99);
        if (len < 75) len = $urandom_range((lim < 8) ? lim : 8);
        else if (len < 95) len = $urandom_range((lim < 40) ? lim : 40);
        else len = $urandom_range((lim < 200) ? lim : 200);
        cmd = $urandom_range(1) ? KNOWN_IDS[$urandom_range(5)] : 16'($urandom_range(16'hFFFF));
        if (pick < 16) begin
          build_frame(LEN_W'(len), 8'($urandom_range(255)), cmd, 1'b0, 8'h00, 1'b1, 1'b0,
                      1'($urandom_range(1)));
        end else if (pick < 25) begin
          build_frame(LEN_W'($urandom_range(16'hFFFF, lim + 1)), 8'($urandom_range(255)), cmd,
                      1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        end else if (pick < 35) begin
          build_frame(LEN_W'(len), 8'($urandom_range(255)), cmd, 1'b0, 8'h00, 1'b0, 1'b1,
                      1'b0);
        end else begin
          build_frame(LEN_W'(len), 8'($urandom_range(255)), cmd, 1'b0, 8'h00, 1'b0, 1'b0,
                      1'b0);
          // Cut some frames short so the next start byte lands mid-frame
          if (pick < 40) frame_buf = frame_buf[0:$urandom_range(frame_buf.size() - 2)];
        end
        tx_bytes = {tx_bytes, frame_buf};
        queued += frame_buf.size();
      end
    end
  endtask

  // Hold until every byte is taken and every expected record has come back
  task automatic wait_drained();
    do @(posedge clk_i); while (tx_bytes.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (pending_recs.size() != 0);
  endtask

  // Present the next request at the falling edge; hold it until taken
  always @(negedge clk_i) begin
    if (!in_valid_i || byte_taken) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= tx_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Predict on accepted requests, score accepted records
  always @(posedge clk_i) begin
    deframe_rec_t want;
    byte_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) deframe_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_recs.size() == 0) begin
          flag_mismatch("record with nothing expected, kind", kind_o, 0);
        end else begin
          want = pending_recs.pop_front();
          if (kind_o != want.kind) flag_mismatch("kind", kind_o, want.kind);
          if (command_id_o != want.command_id)
            flag_mismatch("command_id", command_id_o, want.command_id);
          if (payload_byte_o != want.payload_byte)
            flag_mismatch("payload_byte", payload_byte_o, want.payload_byte);
          if (byte_offset_o != want.byte_offset)
            flag_mismatch("byte_offset", byte_offset_o, want.byte_offset);
          if (payload_length_o != want.payload_length)
            flag_mismatch("payload_length", payload_length_o, want.payload_length);
          if (sequence_res_o != want.sequence_res)
            flag_mismatch("sequence_res", sequence_res_o, want.sequence_res);
          if (known_id_o != want.known_id) flag_mismatch("known_id", known_id_o, want.known_id);
          if (last_o != want.last) flag_mismatch("last", last_o, want.last);
        end
      end
    end
  end

  initial begin
    frame_row_t  row;
    octet_t      filler;
    int unsigned split;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames at the reset limit
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      repeat (row.noise) begin
        do filler = 8'($urandom_range(255)); while (filler == SOF_BYTE);
        tx_bytes.push_back(filler);
      end
      build_frame(row.len, row.seq, row.cmd, row.fill_on, row.fill, row.hdr_bad, row.crc_bad,
                  row.hdr_bad || row.len > limit_now());
      end_notes.push_back('{row.typed, row.want});
      tx_bytes = {tx_bytes, frame_buf};
    end
    wait_drained();

    // Random traffic phases, each with its own limit and idle pattern
    foreach (TRAFFIC_PHASES[p]) begin
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      cfg_we_i = 1'b1;
      cfg_wdata_i = TRAFFIC_PHASES[p].limit_rand ? CFG_W'($urandom_range(1023, 64))
                                                 : TRAFFIC_PHASES[p].limit;
      @(negedge clk_i);
      limit_reg_q = cfg_wdata_i;
      cfg_we_i = 1'b0;
      send_idle_pct = TRAFFIC_PHASES[p].send_pct;
      recv_idle_pct = TRAFFIC_PHASES[p].recv_pct;
      random_traffic(TRAFFIC_PHASES[p].n_bytes);
      if (TRAFFIC_PHASES[p].limit_rand) begin
        // Stop mid-payload until the output side has caught up
        build_frame(16'd6, 8'($urandom_range(255)), CMD_ID_3, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        split = 9;
        tx_bytes = {tx_bytes, frame_buf[0:split-1]};
        wait_drained();
        tx_bytes = {tx_bytes, frame_buf[split:$]};
      end
      // Close a small-limit phase with a frame exactly at the limit
      if (limit_now() < 16) begin
        build_frame(LEN_W'(limit_now()), 8'($urandom_range(255)), CMD_ID_0, 1'b0, 8'h00,
                    1'b0, 1'b0, 1'b0);
        tx_bytes = {tx_bytes, frame_buf};
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
